FILE: hw/rtl/dflr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dflr_pkg
// Types and constants shared by the driver fault latch recovery block.
// ----------------------------------------------------------------------------
package dflr_pkg;

  localparam int DRIVERS   = 5;
  localparam int PIN_W     = 10;
  localparam int OUT_W     = 5;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WAIT_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_PERIOD = 1'd1;

  localparam logic [PERIOD_W-1:0] WAIT_PERIOD_RST  = 16'd5;
  localparam logic [PERIOD_W-1:0] LATCH_PERIOD_RST = 16'd3;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [PIN_W-1:0]  fault_levels;
  } dflr_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] latch_levels;
    logic [OUT_W-1:0] fault_flags;
    logic [OUT_W-1:0] busy_flags;
  } dflr_out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] wait_period_ms;
    logic [PERIOD_W-1:0] latch_period_ms;
  } dflr_cfg_t;

  typedef struct packed {
    logic latch_level;
    logic busy;
  } dflr_stat_t;

endpackage : dflr_pkg
`default_nettype wire

FILE: hw/rtl/dflr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dflr_seq
// Recovery sequencer of one driver: idle, wait period, latch held low.
// ----------------------------------------------------------------------------
module dflr_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [dflr_pkg::TIME_W-1:0] now_ms,
  input  logic                        faulted,
  input  dflr_pkg::dflr_cfg_t         cfg,
  output dflr_pkg::dflr_stat_t        stat_nxt
);
  import dflr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_LATCH = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   detect_stamp_r, detect_stamp_nxt;
  logic [TIME_W-1:0]   latch_stamp_r, latch_stamp_nxt;
  logic [TIME_W-1:0]   elapsed;

  always_comb begin
    phase_nxt        = phase_r;
    detect_stamp_nxt = detect_stamp_r;
    latch_stamp_nxt  = latch_stamp_r;
    elapsed          = '0;
    case (phase_r)
      PH_WAIT: begin
        elapsed = now_ms - detect_stamp_r;
        if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.wait_period_ms}) begin
          phase_nxt       = PH_LATCH;
          latch_stamp_nxt = now_ms;
        end
      end
      PH_LATCH: begin
        elapsed = now_ms - latch_stamp_r;
        if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.latch_period_ms}) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (faulted) begin
          phase_nxt        = PH_WAIT;
          detect_stamp_nxt = now_ms;
        end
      end
    endcase
  end

  assign stat_nxt.latch_level = (phase_nxt != PH_LATCH);
  assign stat_nxt.busy        = (phase_nxt != PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      detect_stamp_r <= detect_stamp_nxt;
      latch_stamp_r  <= latch_stamp_nxt;
    end
  end

endmodule : dflr_seq
`default_nettype wire

FILE: hw/rtl/driver_fault_latch_recovery.sv
`default_nettype none
// ----------------------------------------------------------------------------
// driver_fault_latch_recovery
// Fault supervisor and latch recovery sequencer for a bank of power drivers.
// ----------------------------------------------------------------------------
// One time sample enters per cycle while the output is not stalled. Its
// result passes the input register, then the result register, where it is
// taken. All driver sequencers update in parallel between the two registers,
// each with one 32-bit wrapping subtract and compare, which sets the rate of
// one sample per clock. The result register frees as it is taken, so a
// stalled output holds at most two samples in flight. The user must write
// periods through the cfg port only while no sample is in flight; the block
// itself does not enforce this.
module driver_fault_latch_recovery (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dflr_pkg::dflr_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dflr_pkg::dflr_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [dflr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dflr_pkg::PERIOD_W-1:0]  cfg_wdata
);
  import dflr_pkg::*;

  dflr_cfg_t  cfg_r;
  dflr_in_t   s1_data_r;
  logic       s1_valid_r;
  logic       s1_adv;
  logic       out_valid_r;
  dflr_out_t  out_data_r, out_data_nxt;
  dflr_stat_t stat_nxt [DRIVERS];
  logic [DRIVERS-1:0] faulted;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_period_ms  <= WAIT_PERIOD_RST;
      cfg_r.latch_period_ms <= LATCH_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAIT_PERIOD:  cfg_r.wait_period_ms  <= cfg_wdata;
        REG_LATCH_PERIOD: cfg_r.latch_period_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // per-driver sequencers
  for (genvar g = 0; g < DRIVERS; g++) begin : g_drv
    if (2*g+1 < PIN_W) begin : g_pins
      assign faulted[g] = ~(&s1_data_r.fault_levels[2*g+1:2*g]);
    end else begin : g_nopins
      assign faulted[g] = 1'b1;
    end

    dflr_seq u_seq (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (s1_adv),
      .now_ms   (s1_data_r.now_ms),
      .faulted  (faulted[g]),
      .cfg      (cfg_r),
      .stat_nxt (stat_nxt[g])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    for (int j = 0; j < OUT_W; j++) begin
      if (j < DRIVERS) begin
        out_data_nxt.latch_levels[j] = stat_nxt[j].latch_level;
        out_data_nxt.fault_flags[j]  = faulted[j];
        out_data_nxt.busy_flags[j]   = stat_nxt[j].busy;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_latch_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((~out_data_r.latch_levels & ~out_data_r.busy_flags) == '0))
    else $error("latch pulled low on an idle driver");

  a_in_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("input transfer lost");

  a_stage_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost on advance");

  a_no_adv_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("result overwritten while stalled");
`endif

endmodule : driver_fault_latch_recovery
`default_nettype wire
